// ===== sv/tef32_pkg.sv =====
// Package with the source type codes and float constants for the element converter.
package tef32_pkg;

  typedef enum logic [2:0] {
    SRC_F32  = 3'd0,
    SRC_F16  = 3'd1,
    SRC_BF16 = 3'd2,
    SRC_F64  = 3'd3,
    SRC_I32  = 3'd4,
    SRC_I64  = 3'd5,
    SRC_NONE = 3'd6,
    SRC_RSVD = 3'd7
  } src_type_t;

  localparam logic [31:0] EXP_INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] QNAN_BITS     = 32'h7FC0_0000;
  localparam logic [7:0]  F16_REBIAS    = 8'd112;

  // Normalised magnitude handed from the front stage to the rounding stage.
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic        special;
    logic [31:0] special_bits;
    logic [63:0] mant;
    logic signed [12:0] exp;
  } norm_t;

endpackage

// ===== sv/tef32_front.sv =====
// Front stage: decodes the raw element and normalises its magnitude.
module tef32_front (
  input  logic [2:0]       src_type,
  input  logic [63:0]      raw,
  output tef32_pkg::norm_t nrm
);

  logic [63:0] mag;
  logic signed [12:0] e2;
  logic [5:0]  msb;
  logic [63:0] neg64;
  logic [31:0] neg32;

  always_comb begin
    msb = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) msb = i[5:0];
    end
  end

  always_comb begin
    nrm.sign = 1'b0;
    nrm.special = 1'b0;
    nrm.special_bits = 32'd0;
    mag = 64'd0;
    e2 = 13'sd0;
    neg64 = 64'd0 - raw;
    neg32 = 32'd0 - raw[31:0];
    case (src_type)
      tef32_pkg::SRC_F32: begin
        nrm.special = 1'b1;
        nrm.special_bits = raw[31:0];
      end
      tef32_pkg::SRC_BF16: begin
        nrm.special = 1'b1;
        nrm.special_bits = {raw[15:0], 16'd0};
      end
      tef32_pkg::SRC_F16: begin
        nrm.sign = raw[15];
        if (raw[14:10] == 5'd31) begin
          nrm.special = 1'b1;
          nrm.special_bits = {raw[15], tef32_pkg::EXP_INF_BITS[30:23], raw[9:0], 13'd0};
        end else if (raw[14:10] != 5'd0) begin
          nrm.special = 1'b1;
          nrm.special_bits = {raw[15], {3'd0, raw[14:10]} + tef32_pkg::F16_REBIAS,
                              raw[9:0], 13'd0};
        end else begin
          mag = {54'd0, raw[9:0]};
          e2 = -13'sd24;
        end
      end
      tef32_pkg::SRC_F64: begin
        nrm.sign = raw[63];
        if (raw[62:52] == 11'h7FF) begin
          nrm.special = 1'b1;
          if (raw[51:0] == 52'd0)
            nrm.special_bits = {raw[63], tef32_pkg::EXP_INF_BITS[30:0]};
          else
            nrm.special_bits = {raw[63], tef32_pkg::QNAN_BITS[30:0] | {8'd0, raw[51:29]}};
        end else if (raw[62:52] == 11'd0) begin
          mag = {12'd0, raw[51:0]};
          e2 = -13'sd1074;
        end else begin
          mag = {11'd0, 1'b1, raw[51:0]};
          e2 = $signed({2'b00, raw[62:52]}) - 13'sd1075;
        end
      end
      tef32_pkg::SRC_I32: begin
        nrm.sign = raw[31];
        mag = {32'd0, raw[31] ? neg32 : raw[31:0]};
      end
      tef32_pkg::SRC_I64: begin
        nrm.sign = raw[63];
        mag = raw[63] ? neg64 : raw;
      end
      default: begin
        nrm.special = 1'b1;
      end
    endcase
    nrm.zero = (mag == 64'd0);
    // Left-justify so bit 63 holds the leading one; exponent is the value's binary exponent.
    nrm.mant = mag << (6'd63 - msb);
    nrm.exp = e2 + $signed({7'd0, msb});
  end

endmodule

// ===== sv/tef32_round.sv =====
// Rounding stage: rounds a normalised magnitude to binary32, nearest even.
module tef32_round (
  input  tef32_pkg::norm_t nrm,
  output logic [31:0]      bits
);

  logic signed [12:0] te;
  logic [12:0] sh;
  logic [5:0]  rpos;
  logic [63:0] shifted;
  logic        sticky;
  logic [24:0] keep;
  logic        rbit;
  logic [24:0] r;
  logic [31:0] body;
  logic [63:0] lost_mask;

  always_comb begin
    te = nrm.exp + 13'sd127;
    // Significand of 24 bits normally; fewer bits once below the normal range.
    if (te >= 13'sd1) sh = 13'd40;
    else sh = 13'd40 + 13'($unsigned(13'sd1 - te));
    shifted = (sh >= 13'd64) ? 64'd0 : (nrm.mant >> sh[5:0]);
    keep = shifted[24:0];
    // Beyond a shift of 64 the value is below half the smallest subnormal.
    rpos = sh[5:0] - 6'd1;
    rbit = (sh > 13'd64) ? 1'b0 : nrm.mant[rpos];
    lost_mask = (64'd1 << rpos) - 64'd1;
    sticky = |(nrm.mant & lost_mask);
    r = keep + {24'd0, rbit & (sticky | keep[0])};
    if (te >= 13'sd255) begin
      body = tef32_pkg::EXP_INF_BITS;
    end else if (te >= 13'sd1) begin
      body = ({19'd0, te[12:0]} << 23) + {7'd0, r} - 32'h0080_0000;
      if (body > tef32_pkg::EXP_INF_BITS) body = tef32_pkg::EXP_INF_BITS;
    end else begin
      body = {7'd0, r};
    end
    if (nrm.special) bits = nrm.special_bits;
    else if (nrm.zero) bits = {nrm.sign, 31'd0};
    else bits = {nrm.sign, body[30:0]};
  end

endmodule

// ===== sv/tensor_element_to_float32.sv =====
// Top level of the tensor element to binary32 converter.
// Usage: write cfg_source_type through cfg_we while idle to pick the source format
// (0 F32, 1 F16, 2 BF16, 3 F64, 4 I32, 5 I64, other codes give +0).
// An element beat is taken at each rising edge with start high and busy low;
// busy is always low, so one element may be taken every cycle.
// The raw bits are registered, decoded and normalised into a second register,
// then rounded into the result register that drives out_valid and out_single_bits.
// Throughput is one element per cycle, set by the three register stages with one
// normalise or one round between them.
// Reset (rst_n low, synchronous) clears the valid flags and sets the source
// type to F32. The receiver cannot stall, so no flow control is needed.
module tensor_element_to_float32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_raw_element,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_source_type,
  output logic        out_valid,
  output logic [31:0] out_single_bits
);

  logic [2:0]  src_r;
  logic        in_v_r;
  logic [63:0] raw_r;
  logic        out_v_r;
  logic [31:0] res_r;
  logic [31:0] res_nxt;
  tef32_pkg::norm_t nrm;
  tef32_pkg::norm_t nrm_r;

  assign busy = 1'b0;

  tef32_front u_front (.src_type(src_r), .raw(raw_r), .nrm(nrm));
  tef32_round u_round (.nrm(nrm_r), .bits(res_nxt));

  logic        mid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= tef32_pkg::SRC_F32;
      in_v_r <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) src_r <= cfg_source_type;
      in_v_r <= start & ~busy;
      mid_v_r <= in_v_r;
      out_v_r <= mid_v_r;
    end
    raw_r <= in_raw_element;
    nrm_r <= nrm;
    res_r <= res_nxt;
  end

  assign out_valid = out_v_r;
  assign out_single_bits = res_r;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##2 out_valid) else $error("result beat missing");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(mid_v_r)) else $error("result beat without element");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(src_r, 2) == tef32_pkg::SRC_RSVD
      && $past(src_r) == tef32_pkg::SRC_RSVD && $past(in_v_r, 2))
      |-> out_single_bits == 32'd0) else $error("unsupported type not zero");
`endif

endmodule

// ===== tb/sv/tb_tensor_element_to_float32.sv =====
// Self-checking testbench for the tensor element to binary32 converter.
`timescale 1ns / 100ps

module tb_tensor_element_to_float32;

  class single_scoreboard;
    logic [31:0] pending[$];
    int mismatches;

    function void note_element(logic [31:0] predicted);
      pending = {pending, predicted};
    endfunction

    function void check_single(logic [31:0] actual);
      logic [31:0] wanted;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %08h", actual);
      end else begin
        wanted = pending.pop_front();
        if (wanted !== actual) begin
          mismatches++;
          if (mismatches <= 10)
            $display("single_bits mismatch: expected %08h actual %08h", wanted, actual);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_raw_element;
  logic        cfg_we;
  logic [2:0]  cfg_source_type;
  logic        out_valid;
  logic [31:0] out_single_bits;

  single_scoreboard sb;
  logic [2:0] cur_type;

  tensor_element_to_float32 u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_raw_element(in_raw_element), .cfg_we(cfg_we),
    .cfg_source_type(cfg_source_type), .out_valid(out_valid),
    .out_single_bits(out_single_bits)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tensor_element_to_float32 regression: fail");
    $finish;
  end

  function automatic int top_bit(logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  // Right shift with round to nearest, ties to even; negative shifts go left.
  function automatic logic [63:0] round_shift(logic [63:0] v, int sh);
    logic [63:0] keep, rem, half;
    if (sh <= 0) return (sh <= -64) ? 64'd0 : (v << (-sh));
    if (sh >= 64) return 64'd0;
    keep = v >> sh;
    rem  = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && keep[0])) keep++;
    return keep;
  endfunction

  function automatic logic [31:0] pack_single(logic [31:0] sgn, logic [63:0] mag, int e2);
    int p, te;
    logic [63:0] r;
    logic [31:0] bits;
    if (mag == 0) return sgn;
    p  = top_bit(mag);
    te = p + e2 + 127;
    if (te >= 255) return sgn | tef32_pkg::EXP_INF_BITS;
    if (te >= 1) begin
      r = round_shift(mag, p - 23);
      bits = (te << 23) + r[31:0] - 32'h0080_0000;
      if (bits > tef32_pkg::EXP_INF_BITS) bits = tef32_pkg::EXP_INF_BITS;
      return sgn | bits;
    end
    r = round_shift(mag, -(e2 + 149));
    return sgn | r[31:0];
  endfunction

  function automatic logic [31:0] predict_single(logic [2:0] st, logic [63:0] raw);
    logic [31:0] sgn;
    logic [10:0] e;
    logic [63:0] mag;
    case (st)
      tef32_pkg::SRC_F32:  return raw[31:0];
      tef32_pkg::SRC_BF16: return {raw[15:0], 16'h0};
      tef32_pkg::SRC_F16: begin
        sgn = {raw[15], 31'd0};
        if (raw[14:10] == 0) return pack_single(sgn, {54'd0, raw[9:0]}, -24);
        if (raw[14:10] == 5'h1F)
          return sgn | tef32_pkg::EXP_INF_BITS | {raw[9:0], 13'd0};
        return sgn | ((32'(raw[14:10]) + 32'(tef32_pkg::F16_REBIAS)) << 23)
               | {raw[9:0], 13'd0};
      end
      tef32_pkg::SRC_F64: begin
        sgn = {raw[63], 31'd0};
        e = raw[62:52];
        mag = {12'd0, raw[51:0]};
        if (e == 11'h7FF) begin
          if (mag == 0) return sgn | tef32_pkg::EXP_INF_BITS;
          return sgn | tef32_pkg::QNAN_BITS | 32'(raw[51:29]);
        end
        if (e == 0) return pack_single(sgn, mag, -1074);
        return pack_single(sgn, mag | (64'd1 << 52), int'(e) - 1075);
      end
      tef32_pkg::SRC_I32: begin
        mag = {32'd0, raw[31:0]};
        if (raw[31]) mag = 64'h1_0000_0000 - mag;
        return pack_single({raw[31], 31'd0}, mag, 0);
      end
      tef32_pkg::SRC_I64: begin
        mag = raw[63] ? (64'd0 - raw) : raw;
        return pack_single({raw[63], 31'd0}, mag, 0);
      end
      default: return 32'd0;
    endcase
  endfunction

  // Results cannot be held off, so every strobed cycle is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_single(out_single_bits);
  end

  task automatic send_element(logic [63:0] raw);
    start <= 1'b1;
    in_raw_element <= raw;
    do @(posedge clk); while (busy);
    sb.note_element(predict_single(cur_type, raw));
  endtask

  task automatic send_random_gapped(logic [63:0] raw, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(14, 0) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    send_element(raw);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_type(logic [2:0] st);
    cfg_we <= 1'b1;
    cfg_source_type <= st;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_type = st;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Biased values that land in special regions for the current type.
  function automatic logic [63:0] shaped_element(logic [2:0] st);
    logic [63:0] r;
    r = rand64();
    case ($urandom_range(5, 0))
      0: return r;
      1: return r & 64'h8000_0000_000F_FFFF;
      2: begin
        if (st == tef32_pkg::SRC_F64) r[62:52] = 11'd1023 - 11'($urandom_range(160, 0));
        else if (st == tef32_pkg::SRC_F16) r[14:10] = 5'($urandom_range(1, 0) * 31);
        return r;
      end
      3: begin
        if (st == tef32_pkg::SRC_F64) r[62:52] = 11'd1023 + 11'($urandom_range(130, 120));
        return r;
      end
      4: return r >> $urandom_range(63, 0);
      default: return {$urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0, $urandom()};
    endcase
  endfunction

  initial begin
    logic [2:0] order[$];
    logic [63:0] directed[$];
    sb = new();
    cur_type = tef32_pkg::SRC_F32;
    rst_n = 1'b0;
    start = 1'b0;
    in_raw_element = '0;
    cfg_we = 1'b0;
    cfg_source_type = tef32_pkg::SRC_F32;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset type is F32; check it before any register write.
    send_element(64'hDEAD_BEEF_3F80_0000);
    drain();

    directed = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0001,
                 64'h7FF4_0000_0000_0000, 64'h0000_0000_0000_0001,
                 64'h7FEF_FFFF_FFFF_FFFF, 64'h47EF_FFFF_F000_0000,
                 64'h3690_0000_0000_0000, 64'h36A0_0000_0000_0001,
                 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
                 64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0100_0001,
                 64'h0000_0000_0000_7C01, 64'h0000_0000_0000_FE00,
                 64'h0000_0000_0000_03FF, 64'h0000_0000_0000_8001,
                 64'h0000_0000_0000_7BFF};
    for (int st = 0; st < 8; st++) begin
      set_type(3'(st));
      foreach (directed[i]) send_element(directed[i]);
      drain();
    end

    order = '{tef32_pkg::SRC_F64, tef32_pkg::SRC_F16, tef32_pkg::SRC_I64,
              tef32_pkg::SRC_I32, tef32_pkg::SRC_F32, tef32_pkg::SRC_BF16,
              tef32_pkg::SRC_RSVD, tef32_pkg::SRC_NONE};
    for (int ph = 0; ph < 8; ph++) begin
      set_type(ph < 8 ? order[ph] : tef32_pkg::SRC_F64);
      for (int n = 0; n < 200; n++)
        send_random_gapped(shaped_element(cur_type), (n / 40) % 2 == 1);
      drain();
    end

    start <= 1'b0;
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tensor_element_to_float32 regression: pass");
    end else begin
      $display("tensor_element_to_float32 regression: fail");
    end
    $finish;
  end

endmodule
